// File: design/ffca_pkg.sv
// shared types, constants and helpers for the first-fit coalescing allocator
// no dependencies
package ffca_pkg;

  localparam int MAX_FRAGMENTS = 16;
  localparam int ALIGN_BYTES   = 8;
  localparam int HEADER_BYTES  = 8;
  localparam int MIN_CHUNK     = 16;
  localparam int PAD_BYTES     = 0;
  localparam int ADDR_BITS     = 16;

  localparam int LEN_BITS   = 17;
  localparam int IDX_BITS   = $clog2(MAX_FRAGMENTS);
  localparam int CNT_BITS   = $clog2(MAX_FRAGMENTS + 1);
  localparam int ALIGN_BITS = $clog2(ALIGN_BYTES);
  localparam int HDR_BITS   = ADDR_BITS - ALIGN_BITS;
  localparam int HDR_DEPTH  = 1 << HDR_BITS;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_BITS   = 17;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ARENA_BASE = 1'b0,
    REG_ARENA_SIZE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_SIZE_BAD  = 3'd3,
    ST_ALREADY   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                 command;
    logic [15:0]          request_bytes;
    logic [ADDR_BITS-1:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] payload_address;
    logic [LEN_BITS-1:0]  granted_size;
  } out_word_t;

  // one table entry as handed between cells
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } seg_t;

  // shift control from sequencer to the chain
  typedef enum logic [2:0] {
    SH_HOLD  = 3'd0,
    SH_LOAD  = 3'd1,
    SH_WRITE = 3'd2,
    SH_INS   = 3'd3,
    SH_DEL   = 3'd4
  } shift_e;

  typedef struct packed {
    shift_e              op;
    logic [IDX_BITS-1:0] pos;
    seg_t                data;
  } chain_ctl_t;

  // saturating length add
  function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                  input logic [LEN_BITS-1:0] b);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
  endfunction

endpackage

// File: design/ffca_cell.sv
// one cell of the free segment chain: holds one table entry
// depends on ffca_pkg
module ffca_cell import ffca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chain_ctl_t          ctl_i,
  input  logic [IDX_BITS-1:0] my_idx_i,
  input  seg_t                init_i,
  input  seg_t                prev_i,
  input  seg_t                next_i,
  output seg_t                seg_o
);

  seg_t seg_q, seg_d;

  // select the new contents by shift operation
  always_comb begin
    seg_d = seg_q;
    case (ctl_i.op)
      SH_LOAD:  seg_d = init_i;
      SH_WRITE: if (my_idx_i == ctl_i.pos) seg_d = ctl_i.data;
      SH_INS: begin
        if (my_idx_i == ctl_i.pos) seg_d = ctl_i.data;
        else if (my_idx_i > ctl_i.pos) seg_d = prev_i;
      end
      SH_DEL:   if (my_idx_i >= ctl_i.pos) seg_d = next_i;
      default:  seg_d = seg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

// File: design/ffca_chain.sv
// row of segment cells, each shifts to or from its neighbors
// depends on ffca_pkg, ffca_cell
module ffca_chain import ffca_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  seg_t       init_i,
  input  logic [IDX_BITS-1:0] rd_idx_i,
  output seg_t       rd_o,
  output seg_t       rd_next_o
);

  seg_t segs [MAX_FRAGMENTS];

  for (genvar g = 0; g < MAX_FRAGMENTS; g++) begin : g_cell
    seg_t prev_s, next_s;
    if (g == 0) begin : g_first
      assign prev_s = '0;
    end else begin : g_mid
      assign prev_s = segs[g-1];
    end
    if (g == MAX_FRAGMENTS - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_rest
      assign next_s = segs[g+1];
    end
    ffca_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i,
      .my_idx_i (IDX_BITS'(g)),
      .init_i   (g == 0 ? init_i : seg_t'('0)),
      .prev_i   (prev_s),
      .next_i   (next_s),
      .seg_o    (segs[g])
    );
  end

  // read port for the sequencer walking the table
  assign rd_o      = segs[rd_idx_i];
  assign rd_next_o = (rd_idx_i == IDX_BITS'(MAX_FRAGMENTS - 1)) ? seg_t'('0)
                                                                : segs[rd_idx_i + 1'b1];

endmodule

// File: design/first_fit_coalescing_allocator.sv
// first-fit free list allocator with coalescing; top level and sequencer
// Steps: an allocate goes PREP, WALK over the entries visited, DONE; a free goes PREP,
// then HDR unless outside the arena, then WALK, FIX, MRG on a three-way merge, and DONE.
// A size error leaves HDR for DONE. One word in flight; the next is taken the cycle after the
// result register loads, so output stalls delay the next word.
// Reset: asynchronous, active low; the table reloads to one arena segment after reset.
// depends on ffca_pkg, ffca_chain
module first_fit_coalescing_allocator import ffca_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_data_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_HDR   = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_MRG   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [ADDR_BITS-1:0] base_q;
  logic [LEN_BITS-1:0]  size_q;
  logic        reinit_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;
  logic [CNT_BITS-1:0] pos_q, pos_d;
  in_word_t  req_q;
  out_word_t res_q, res_d;
  logic      ov_q;
  logic      out_load;
  logic [LEN_BITS-1:0] need_q;
  logic [ADDR_BITS-1:0] chunk_q;
  logic [LEN_BITS-1:0] hdr_mem [HDR_DEPTH];
  logic [LEN_BITS-1:0] hdr_rd_q;
  logic                hdr_we;
  logic [HDR_BITS-1:0] hdr_wa;
  logic [LEN_BITS-1:0] hdr_wd;
  chain_ctl_t ctl;
  seg_t init_seg, rd_seg, rd_next;
  logic in_acc;

  // arena bounds
  logic [16:0] lo, end_c, hi, alen;
  logic [17:0] end_raw;
  logic        init_ok;
  always_comb begin
    lo      = ({1'b0, base_q} + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
    end_raw = {2'b0, base_q} + {1'b0, size_q};
    end_c   = (end_raw > 18'h10000) ? 17'h10000 : end_raw[16:0];
    alen    = (end_c > lo) ? ((end_c - lo) & ~17'(ALIGN_BYTES - 1)) : 17'd0;
    hi      = lo + alen;
    init_ok = alen >= 17'(MIN_CHUNK);
    init_seg.start = lo[ADDR_BITS-1:0];
    init_seg.len   = alen;
  end

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || reinit_q;
  assign out_load   = (state_q == S_DONE) && (!ov_q || !out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      size_q   <= 17'h10000;
      reinit_q <= 1'b1;
    end else begin
      reinit_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_ARENA_BASE: base_q <= cfg_data_i[15:0];
          REG_ARENA_SIZE: size_q <= cfg_data_i;
          default: ;
        endcase
        reinit_q <= 1'b1;
      end
    end
  end

  logic [16:0] need_c;
  logic [17:0] rnd;
  logic [16:0] chunk_c;
  logic        in_range;
  logic        walk_end;
  logic [LEN_BITS-1:0] csz;
  logic [17:0] cend;
  logic [16:0] split_len;
  logic [16:0] grant_top;
  logic        p_zero, p_valid;
  seg_t        q_seg, p_seg;
  logic [17:0] q_end;
  logic [LEN_BITS-1:0] mrg_len;
  logic [17:0] mrg_end;

  // header store, read address follows the held input word
  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_rd_q <= hdr_mem[chunk_c[ADDR_BITS-1:ALIGN_BITS]];
  end

  ffca_chain u_chain (
    .clk_i, .rst_ni, .ctl_i(ctl), .init_i(init_seg),
    .rd_idx_i(idx_q), .rd_o(rd_seg), .rd_next_o(rd_next)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    res_d   = res_q;
    ctl     = '{op: SH_HOLD, pos: '0, data: '0};
    hdr_we  = 1'b0;
    hdr_wa  = '0;
    hdr_wd  = '0;
    rnd     = ({2'b0, req_q.request_bytes} + 18'(ALIGN_BYTES - 1)) & ~18'(ALIGN_BYTES - 1);
    need_c  = 17'(rnd + 18'(PAD_BYTES + HEADER_BYTES));
    if (need_c < 17'(MIN_CHUNK)) need_c = 17'(MIN_CHUNK);
    chunk_c  = {1'b0, req_q.free_address} - 17'(HEADER_BYTES);
    in_range = (req_q.free_address >= 16'(HEADER_BYTES)) && chunk_c >= lo && chunk_c < hi;
    csz      = hdr_rd_q;
    cend     = {2'b0, chunk_q} + {1'b0, csz};
    walk_end = ({1'b0, idx_q} >= cnt_q);
    split_len = rd_seg.len - need_q;
    grant_top = {1'b0, rd_seg.start} + split_len;
    // neighbors of the freed chunk: q below, p above
    p_zero  = (pos_q == '0);
    p_valid = pos_q < cnt_q;
    q_seg   = rd_seg;
    p_seg   = p_zero ? rd_seg : rd_next;
    q_end   = {2'b0, q_seg.start} + {1'b0, q_seg.len};
    mrg_len = sat_add(q_seg.len, csz);
    mrg_end = {2'b0, q_seg.start} + {1'b0, mrg_len};

    if (reinit_q) begin
      ctl.op = SH_LOAD;
      cnt_d  = init_ok ? CNT_BITS'(1) : '0;
    end

    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_acc) state_d = S_PREP;
      end
      S_PREP: begin
        res_d = '{status: ST_OK, payload_address: '0, granted_size: '0};
        if (req_q.command == CMD_ALLOC) begin
          state_d = S_WALK;
        end else if (!in_range) begin
          res_d.status = ST_OUTSIDE;
          state_d = S_DONE;
        end else begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (req_q.request_bytes != 16'd0 &&
            ({1'b0, req_q.request_bytes} + 17'(HEADER_BYTES)) > csz) begin
          res_d.status = ST_SIZE_BAD;
          state_d = S_DONE;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (req_q.command == CMD_ALLOC) begin
          if (walk_end) begin
            res_d.status = ST_NO_SPACE;
            state_d = S_DONE;
          end else if (rd_seg.len >= need_q) begin
            state_d = S_DONE;
            hdr_we  = 1'b1;
            if (split_len >= 17'(MIN_CHUNK)) begin
              // split: the top part is granted
              ctl = '{op: SH_WRITE, pos: idx_q,
                      data: '{start: rd_seg.start, len: split_len}};
              hdr_wa = grant_top[ADDR_BITS-1:ALIGN_BITS];
              hdr_wd = need_q;
              res_d.payload_address = grant_top[ADDR_BITS-1:0] + 16'(HEADER_BYTES);
              res_d.granted_size = need_q;
            end else begin
              // whole segment leaves the table
              ctl = '{op: SH_DEL, pos: idx_q, data: '0};
              cnt_d = cnt_q - 1'b1;
              hdr_wa = rd_seg.start[ADDR_BITS-1:ALIGN_BITS];
              hdr_wd = rd_seg.len;
              res_d.payload_address = rd_seg.start + 16'(HEADER_BYTES);
              res_d.granted_size = rd_seg.len;
            end
          end else begin
            idx_d = idx_q + 1'b1;
            if (idx_q == IDX_BITS'(MAX_FRAGMENTS - 1)) begin
              res_d.status = ST_NO_SPACE;
              state_d = S_DONE;
            end
          end
        end else begin
          // find first entry with start above chunk, park the read on the one below
          if (walk_end || rd_seg.start > chunk_q) begin
            state_d = S_FIX;
            pos_d   = {1'b0, idx_q};
            idx_d   = (idx_q == '0) ? '0 : idx_q - 1'b1;
          end else if (idx_q == IDX_BITS'(MAX_FRAGMENTS - 1)) begin
            state_d = S_FIX;
            pos_d   = CNT_BITS'(MAX_FRAGMENTS);
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FIX: begin
        state_d = S_DONE;
        res_d.granted_size = csz;
        if (p_zero) begin
          if (cnt_q != '0 && cend == {2'b0, p_seg.start}) begin
            ctl = '{op: SH_WRITE, pos: '0,
                    data: '{start: chunk_q, len: sat_add(csz, p_seg.len)}};
          end else if (cnt_q >= CNT_BITS'(MAX_FRAGMENTS)) begin
            res_d.status = ST_FULL;
          end else begin
            ctl = '{op: SH_INS, pos: '0, data: '{start: chunk_q, len: csz}};
            cnt_d = cnt_q + 1'b1;
          end
        end else if (q_end == {2'b0, chunk_q}) begin
          if (p_valid && mrg_end == {2'b0, p_seg.start}) begin
            // three-way merge: widen the lower entry, drop the upper one next cycle
            ctl = '{op: SH_WRITE, pos: idx_q,
                    data: '{start: q_seg.start, len: sat_add(mrg_len, p_seg.len)}};
            state_d = S_MRG;
          end else begin
            ctl = '{op: SH_WRITE, pos: idx_q, data: '{start: q_seg.start, len: mrg_len}};
          end
        end else if (q_end > {2'b0, chunk_q}) begin
          res_d.status = ST_ALREADY;
        end else if (p_valid && cend == {2'b0, p_seg.start}) begin
          ctl = '{op: SH_WRITE, pos: IDX_BITS'(pos_q),
                  data: '{start: chunk_q, len: sat_add(csz, p_seg.len)}};
        end else if (cnt_q >= CNT_BITS'(MAX_FRAGMENTS)) begin
          res_d.status = ST_FULL;
        end else begin
          ctl = '{op: SH_INS, pos: IDX_BITS'(pos_q), data: '{start: chunk_q, len: csz}};
          cnt_d = cnt_q + 1'b1;
        end
        if (res_d.status != ST_OK) res_d.granted_size = '0;
      end
      S_MRG: begin
        ctl = '{op: SH_DEL, pos: IDX_BITS'(pos_q), data: '0};
        cnt_d = cnt_q - 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_BITS'(1);
      idx_q   <= '0;
      pos_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      if (out_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    if (state_q == S_PREP) begin
      need_q  <= need_c;
      chunk_q <= chunk_c[ADDR_BITS-1:0];
    end
    res_q <= res_d;
    if (out_load) out_data_o <= res_q;
  end

  assign out_valid_o = ov_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_FRAGMENTS)) else $error("segment count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.granted_size == '0)
    else $error("nonzero size on failure");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

endmodule
